/* rtl/bpd_pkg.sv */
package bpd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [2:0] KIND_PIXEL     = 3'd0;
  localparam logic [2:0] KIND_DONE      = 3'd1;
  localparam logic [2:0] KIND_BAD_SIG   = 3'd2;
  localparam logic [2:0] KIND_UNSUPP    = 3'd3;
  localparam logic [2:0] KIND_TRUNCATED = 3'd4;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic        last;
  } bpd_rec_t;

  // up to two records per byte; rec0 is filled first
  typedef struct packed {
    logic     vld0;
    logic     vld1;
    bpd_rec_t rec0;
    bpd_rec_t rec1;
  } bpd_wr_t;

  function automatic bpd_rec_t bpd_end_rec(input logic [2:0] kind,
                                           input logic [12:0] fw,
                                           input logic [12:0] fh);
    bpd_rec_t r;
    r = '0;
    r.item_kind    = kind;
    r.frame_width  = fw;
    r.frame_height = fh;
    r.last         = 1'b1;
    return r;
  endfunction

endpackage

/* rtl/bpd_front.sv */
module bpd_front
  import bpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  input  logic       fmt_ppm,
  output bpd_wr_t    wr
);

  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_BMP_HDR    = 4'd1;
  localparam logic [3:0] PH_BMP_BAD    = 4'd2;
  localparam logic [3:0] PH_BMP_SKIP   = 4'd3;
  localparam logic [3:0] PH_BMP_PIX    = 4'd4;
  localparam logic [3:0] PH_PPM_SIG    = 4'd5;
  localparam logic [3:0] PH_PPM_SPACE  = 4'd6;
  localparam logic [3:0] PH_PPM_DIGITS = 4'd7;
  localparam logic [3:0] PH_PPM_PIX    = 4'd8;
  localparam logic [3:0] PH_DISCARD    = 4'd9;

  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] fbc_r, fbc_nxt;
  logic [31:0] hc_r, hc_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [12:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic        four_r, four_nxt;
  logic        bu_r, bu_nxt;
  logic [11:0] rowc_r, rowc_nxt;
  logic [14:0] bir_r, bir_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [11:0] col_r, col_nxt;
  logic [15:0] pix_r, pix_nxt;
  logic [24:0] acc_r, acc_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        cmt_r, cmt_nxt;

  logic        is_digit, do_pix, is_ppm_pix, bad, nd;
  logic        pix_emit, end_emit;
  bpd_rec_t    pix_rec, end_rec;
  logic [31:0] hc_w, mag;
  logic [28:0] acc_mul;
  logic [14:0] data_len, p1;
  logic [15:0] stride;
  logic [1:0]  ch_last;
  logic [12:0] rowc_inc;

  assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign hc_w     = {data_byte, hc_r[31:8]};
  assign mag      = hc_w[31] ? (~hc_w + 32'd1) : hc_w;
  assign acc_mul  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                    + {21'b0, data_byte - CH_0};
  assign is_ppm_pix = (phase_r == PH_PPM_PIX);
  assign data_len = (four_r && !is_ppm_pix) ? {width_r, 2'b00}
                    : ({1'b0, width_r, 1'b0} + {2'b0, width_r});
  assign stride   = is_ppm_pix ? {1'b0, data_len}
                    : (({1'b0, data_len} + 16'd3) & ~16'd3);
  assign ch_last  = (four_r && !is_ppm_pix) ? 2'd3 : 2'd2;
  assign p1       = bir_r + 15'd1;
  assign rowc_inc = {1'b0, rowc_r} + 13'd1;

  always_comb begin
    phase_nxt  = phase_r;  fbc_nxt    = fbc_r;    hc_nxt     = hc_r;
    offset_nxt = offset_r; width_nxt  = width_r;  height_nxt = height_r;
    four_nxt   = four_r;   bu_nxt     = bu_r;     rowc_nxt   = rowc_r;
    bir_nxt    = bir_r;    ch_nxt     = ch_r;     col_nxt    = col_r;
    pix_nxt    = pix_r;    acc_nxt    = acc_r;    idx_nxt    = idx_r;
    cmt_nxt    = cmt_r;
    do_pix   = 1'b0;
    bad      = 1'b0;
    pix_emit = 1'b0;
    pix_rec  = '0;
    end_emit = 1'b0;
    end_rec  = '0;

    unique case (phase_r)
      PH_START: begin
        if (fmt_ppm) begin
          if (data_byte != CH_P) begin
            end_emit = 1'b1; end_rec = bpd_end_rec(KIND_BAD_SIG, '0, '0);
            phase_nxt = PH_DISCARD;
          end else begin
            phase_nxt = PH_PPM_SIG;
          end
        end else begin
          if (data_byte != CH_B) begin
            end_emit = 1'b1; end_rec = bpd_end_rec(KIND_BAD_SIG, '0, '0);
            phase_nxt = PH_DISCARD;
          end else begin
            fbc_nxt = 32'd1;
            phase_nxt = PH_BMP_HDR;
          end
        end
      end
      PH_BMP_HDR, PH_BMP_BAD: begin
        hc_nxt = hc_w;
        if (phase_r == PH_BMP_HDR && fbc_r == 32'd1 && data_byte != CH_M) begin
          end_emit = 1'b1; end_rec = bpd_end_rec(KIND_BAD_SIG, '0, '0);
          phase_nxt = PH_DISCARD;
        end else begin
          if (phase_r == PH_BMP_HDR) begin
            if (fbc_r == 32'd13) begin
              offset_nxt = hc_w;
              bad = (hc_w < 32'd54);
            end else if (fbc_r == 32'd17) begin
              bad = (hc_w < 32'd40);
            end else if (fbc_r == 32'd21) begin
              if (hc_w == '0 || hc_w > 32'(MAX_WIDTH)) bad = 1'b1;
              else width_nxt = hc_w[12:0];
            end else if (fbc_r == 32'd25) begin
              bu_nxt = !hc_w[31];
              if (mag == '0 || mag > 32'(MAX_HEIGHT)) bad = 1'b1;
              else height_nxt = mag[12:0];
            end else if (fbc_r == 32'd29) begin
              if (hc_w[31:16] == 16'd24) four_nxt = 1'b0;
              else if (hc_w[31:16] == 16'd32) four_nxt = 1'b1;
              else bad = 1'b1;
            end else if (fbc_r == 32'd33) begin
              bad = (hc_w != '0);
            end
          end
          fbc_nxt = fbc_r + 32'd1;
          if (fbc_r >= 32'd53) begin
            if (phase_r == PH_BMP_BAD || bad) begin
              end_emit = 1'b1; end_rec = bpd_end_rec(KIND_UNSUPP, '0, '0);
              phase_nxt = PH_DISCARD;
            end else begin
              phase_nxt = PH_BMP_SKIP;
            end
          end else if (bad) begin
            phase_nxt = PH_BMP_BAD;
          end
        end
      end
      PH_BMP_SKIP: begin
        if (fbc_r == offset_r) begin
          phase_nxt = PH_BMP_PIX;
          do_pix = 1'b1;
        end else begin
          fbc_nxt = fbc_r + 32'd1;
        end
      end
      PH_BMP_PIX, PH_PPM_PIX: do_pix = 1'b1;
      PH_PPM_SIG: begin
        if (data_byte != CH_6) begin
          end_emit = 1'b1; end_rec = bpd_end_rec(KIND_BAD_SIG, '0, '0);
          phase_nxt = PH_DISCARD;
        end else begin
          phase_nxt = PH_PPM_SPACE;
        end
      end
      PH_PPM_SPACE: begin
        if (cmt_r) begin
          if (data_byte == CH_LF) cmt_nxt = 1'b0;
        end else if (data_byte == CH_HASH) begin
          cmt_nxt = 1'b1;
        end else if (data_byte == CH_SP || data_byte == CH_TAB
                     || data_byte == CH_CR || data_byte == CH_LF) begin
          cmt_nxt = 1'b0;
        end else if (is_digit) begin
          acc_nxt = {17'b0, data_byte - CH_0};
          phase_nxt = PH_PPM_DIGITS;
        end else begin
          end_emit = 1'b1; end_rec = bpd_end_rec(KIND_UNSUPP, '0, '0);
          phase_nxt = PH_DISCARD;
        end
      end
      PH_PPM_DIGITS: begin
        if (is_digit) begin
          acc_nxt = acc_mul[24:0];
          if (acc_mul > 29'(1 << 24)) begin
            end_emit = 1'b1; end_rec = bpd_end_rec(KIND_UNSUPP, '0, '0);
            phase_nxt = PH_DISCARD;
          end
        end
      end
      default: ;
    endcase

    // one pixel-data byte: BMP rows are padded to 4 bytes
    if (do_pix) begin
      if ({1'b0, bir_r} < {1'b0, data_len}) begin
        unique case (ch_r)
          2'd0: pix_nxt[7:0] = data_byte;
          2'd1: pix_nxt[15:8] = data_byte;
          2'd2: begin
            pix_emit = 1'b1;
            pix_rec.item_kind = KIND_PIXEL;
            pix_rec.green = pix_r[15:8];
            pix_rec.column = col_r;
            pix_rec.row = bu_r ? 12'(height_r - 13'd1 - {1'b0, rowc_r}) : rowc_r;
            if (is_ppm_pix) begin
              pix_rec.blue = data_byte; pix_rec.red = pix_r[7:0];
            end else begin
              pix_rec.blue = pix_r[7:0]; pix_rec.red = data_byte;
            end
          end
          default: ;
        endcase
        if (ch_r == ch_last) begin
          ch_nxt = 2'd0;
          col_nxt = col_r + 12'd1;
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      bir_nxt = p1;
      if ({1'b0, p1} >= stride) begin
        bir_nxt = '0;
        ch_nxt = 2'd0;
        col_nxt = '0;
        rowc_nxt = rowc_inc[11:0];
        if (rowc_inc >= height_r) begin
          end_emit = 1'b1;
          end_rec = bpd_end_rec(KIND_DONE, width_r, height_r);
          phase_nxt = PH_DISCARD;
        end
      end
    end

    // end of a header number: on a delimiter, or forced by end of file
    nd = (phase_r == PH_PPM_DIGITS && !is_digit)
         || (end_of_file && phase_nxt == PH_PPM_DIGITS);
    if (nd) begin
      unique case (idx_r)
        2'd0, 2'd1: begin
          if (acc_nxt == '0
              || acc_nxt > ((idx_r == 2'd0) ? 25'(MAX_WIDTH) : 25'(MAX_HEIGHT))) begin
            end_emit = 1'b1; end_rec = bpd_end_rec(KIND_UNSUPP, '0, '0);
            phase_nxt = PH_DISCARD;
          end else begin
            if (idx_r == 2'd0) width_nxt = acc_nxt[12:0];
            else height_nxt = acc_nxt[12:0];
            idx_nxt = idx_r + 2'd1;
            acc_nxt = '0;
            phase_nxt = PH_PPM_SPACE;
          end
        end
        default: begin
          if (acc_nxt != 25'd255) begin
            end_emit = 1'b1; end_rec = bpd_end_rec(KIND_UNSUPP, '0, '0);
            phase_nxt = PH_DISCARD;
          end else begin
            phase_nxt = PH_PPM_PIX;
          end
        end
      endcase
    end

    if (end_of_file) begin
      if (!end_emit) begin
        if (phase_nxt == PH_BMP_HDR || phase_nxt == PH_BMP_BAD
            || phase_nxt == PH_PPM_SIG) begin
          end_emit = 1'b1; end_rec = bpd_end_rec(KIND_BAD_SIG, '0, '0);
        end else if (phase_nxt == PH_PPM_SPACE) begin
          end_emit = 1'b1; end_rec = bpd_end_rec(KIND_UNSUPP, '0, '0);
        end else if (phase_nxt == PH_BMP_SKIP || phase_nxt == PH_BMP_PIX
                     || phase_nxt == PH_PPM_PIX) begin
          end_emit = 1'b1; end_rec = bpd_end_rec(KIND_TRUNCATED, '0, '0);
        end
      end
      phase_nxt  = PH_START; fbc_nxt = '0; hc_nxt = '0; offset_nxt = '0;
      width_nxt  = '0; height_nxt = '0; four_nxt = 1'b0; bu_nxt = 1'b0;
      rowc_nxt   = '0; bir_nxt = '0; ch_nxt = '0; col_nxt = '0; pix_nxt = '0;
      acc_nxt    = '0; idx_nxt = '0; cmt_nxt = 1'b0;
    end
  end

  always_comb begin
    wr.vld0 = fire && (pix_emit || end_emit);
    wr.vld1 = fire && pix_emit && end_emit;
    wr.rec0 = pix_emit ? pix_rec : end_rec;
    wr.rec1 = end_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START; fbc_r <= '0; hc_r <= '0; offset_r <= '0;
      width_r <= '0; height_r <= '0; four_r <= 1'b0; bu_r <= 1'b0;
      rowc_r <= '0; bir_r <= '0; ch_r <= '0; col_r <= '0; pix_r <= '0;
      acc_r <= '0; idx_r <= '0; cmt_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt; fbc_r <= fbc_nxt; hc_r <= hc_nxt; offset_r <= offset_nxt;
      width_r <= width_nxt; height_r <= height_nxt; four_r <= four_nxt; bu_r <= bu_nxt;
      rowc_r <= rowc_nxt; bir_r <= bir_nxt; ch_r <= ch_nxt; col_r <= col_nxt;
      pix_r <= pix_nxt; acc_r <= acc_nxt; idx_r <= idx_nxt; cmt_r <= cmt_nxt;
    end
  end

endmodule

/* rtl/bpd_result_queue.sv */
module bpd_result_queue
  import bpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  bpd_wr_t  wr,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output bpd_rec_t head
);

  bpd_rec_t           mem [RQ_DEPTH];
  logic [RQ_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [RQ_AW:0]     cnt_r, cnt_nxt;
  logic               rd;
  logic [RQ_AW:0]     n_wr;

  assign empty = (cnt_r == '0);
  // room for two records is needed before a byte is taken
  assign full  = (cnt_r > (RQ_AW+1)'(RQ_DEPTH - 2));
  assign rd    = pop && !empty;
  assign head  = mem[rp_r];
  assign n_wr  = (RQ_AW+1)'(wr.vld0) + (RQ_AW+1)'(wr.vld1);

  always_comb begin
    wp_nxt  = wp_r + RQ_AW'(n_wr);
    rp_nxt  = rp_r + RQ_AW'(rd);
    cnt_nxt = cnt_r + n_wr - (RQ_AW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (wr.vld0) mem[wp_r] <= wr.rec0;
    if (wr.vld1) mem[wp_r + RQ_AW'(1)] <= wr.rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/bmp_ppm_pixel_decoder_unit.sv */
// Channel | Ports                                   | Beat taken when
// --------+-----------------------------------------+--------------------
// input   | in_data_byte, in_end_of_file            | push && !full
// result  | out_item_kind .. out_last               | pop && !empty
// config  | cfg_image_format                        | cfg_valid && cfg_ready
//
// One file byte per cycle while full is low. The parser settles the byte
// in the cycle it is taken and writes zero, one or two result records into
// a 4-entry queue. full rises while fewer than two queue slots are free;
// results leave the queue in order, behind older ones. Sync active-low
// reset clears the parser to header start and empties the queue. cfg_ready
// is always high; the format is sampled on the first byte of each file.
module bmp_ppm_pixel_decoder_unit
  import bpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_item_kind,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic [12:0] out_frame_width,
  output logic [12:0] out_frame_height,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_image_format
);

  logic     fmt_r;
  logic     fire;
  bpd_wr_t  wr;
  bpd_rec_t head;

  assign cfg_ready = 1'b1;
  assign fire      = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
    end else if (cfg_valid) begin
      fmt_r <= cfg_image_format;
    end
  end

  // front: byte parser / classifier
  bpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .fmt_ppm     (fmt_r),
    .wr          (wr)
  );

  // back: result queue driving the output side
  bpd_result_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .head  (head)
  );

  assign out_item_kind    = head.item_kind;
  assign out_blue         = head.blue;
  assign out_green        = head.green;
  assign out_red          = head.red;
  assign out_column       = head.column;
  assign out_row          = head.row;
  assign out_frame_width  = head.frame_width;
  assign out_frame_height = head.frame_height;
  assign out_last         = head.last;

endmodule
